>>> sv/nldm_pkg.sv
package nldm_pkg;

   // fixed sizes; the port widths are built for these
   localparam int unsigned NUM_TABLES    = 64;
   localparam int unsigned NUM_TEMPLATES = 16;
   localparam int unsigned GRID_POINTS   = 7;
   localparam int unsigned FRAC_BITS     = 20;

   typedef enum logic [1:0] {
      ACT_ENTRY = 2'd0,
      ACT_AXIS  = 2'd1,
      ACT_BIND  = 2'd2,
      ACT_QUERY = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_WRITE = 2'd0,
      ST_OK    = 2'd1,
      ST_GAP   = 2'd2,
      ST_SAT   = 2'd3
   } status_type;

   // shared unit operations
   typedef enum logic [1:0] {
      OP_DIV  = 2'd0,
      OP_LERP = 2'd1
   } op_type;

   typedef struct packed {
      logic  start;
      op_type op;
   } alu_ctl_type;

   typedef struct packed {
      logic done;
      logic sat;
   } alu_sts_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_MAP,
      S_TSCAN_REQ,
      S_TSCAN,
      S_THI,
      S_TDIV,
      S_TWAIT,
      S_LSCAN_REQ,
      S_LSCAN,
      S_LHI,
      S_LDIV,
      S_LWAIT,
      S_E0,
      S_E1,
      S_E2,
      S_E3,
      S_E4,
      S_M1,
      S_M1W,
      S_M2,
      S_M2W,
      S_R,
      S_RW,
      S_OUT
   } state_type;

   localparam int unsigned VAL_W = 32;

endpackage

>>> sv/nldm_alu.sv
// Shared arithmetic unit: restoring divider for axis fractions (one quotient bit
// a cycle) and a lerp step (one multiply, registered, then shift and add).
module nldm_alu
   import nldm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  alu_ctl_type        ctl,
   input  logic signed [32:0] opa,   // div: q - a_lo   lerp: a
   input  logic signed [32:0] opb,   // div: den        lerp: b
   input  logic signed [31:0] opf,   // lerp fraction
   output logic signed [31:0] res,
   output alu_sts_type        sts
);

   localparam int unsigned NUM_W = 33 + FRAC_BITS;
   localparam int unsigned CNT_W = $clog2(NUM_W + 1);
   localparam logic signed [63:0] FLIM = 64'sd1 <<< 30;

   logic              busy_ff, busy_in;
   op_type            op_ff, op_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [NUM_W-1:0]  quo_ff, quo_in;
   logic [33:0]       rem_ff, rem_in;
   logic [32:0]       den_ff, den_in;
   logic              neg_ff, neg_in;
   logic signed [32:0] a_ff, a_in;
   logic signed [63:0] prod_ff, prod_in;
   logic signed [31:0] res_ff, res_in;
   logic              sat_ff, sat_in;
   logic              done_ff, done_in;

   logic [32:0]        num_mag;
   logic signed [33:0] diff;
   logic [33:0]        trial;
   logic signed [NUM_W:0] qs;
   logic signed [64:0] sum;
   logic signed [63:0] fl;

   always_comb begin
      num_mag = opa[32] ? 33'(-opa) : 33'(opa);
      diff    = 34'(opb) - 34'(opa);
      trial   = {rem_ff[32:0], quo_ff[NUM_W-1]};
      qs      = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
      fl      = prod_ff >>> FRAC_BITS;
      sum     = 65'(a_ff) + 65'(fl);
   end

   always_comb begin
      busy_in = busy_ff;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      a_in    = a_ff;
      prod_in = prod_ff;
      res_in  = res_ff;
      sat_in  = sat_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         busy_in = 1'b1;
         op_in   = ctl.op;
         cnt_in  = '0;
         if (ctl.op == OP_DIV) begin
            // opa numerator, opb signed denominator
            quo_in = NUM_W'({num_mag, {FRAC_BITS{1'b0}}});
            rem_in = '0;
            den_in = opb[32] ? 33'(-opb) : 33'(opb);
            neg_in = opa[32] ^ opb[32];
         end else begin
            a_in    = opa;
            prod_in = 64'(diff) * 64'(opf);
         end
      end else if (busy_ff) begin
         if (op_ff == OP_DIV) begin
            if (trial >= {1'b0, den_ff}) begin
               rem_in = trial - {1'b0, den_ff};
               quo_in = {quo_ff[NUM_W-2:0], 1'b1};
            end else begin
               rem_in = trial;
               quo_in = {quo_ff[NUM_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(NUM_W)) begin
               busy_in = 1'b0;
               done_in = 1'b1;
               cnt_in  = cnt_ff;
               rem_in  = rem_ff;
               quo_in  = quo_ff;
               if (64'(qs) > FLIM) begin
                  res_in = 32'(FLIM);  sat_in = 1'b1;
               end else if (64'(qs) < -FLIM) begin
                  res_in = 32'(-FLIM); sat_in = 1'b1;
               end else begin
                  res_in = 32'(qs);    sat_in = 1'b0;
               end
            end
         end else begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (sum > 65'sh7fffffff) begin
               res_in = 32'sh7fffffff; sat_in = 1'b1;
            end else if (sum < -65'sh80000000) begin
               res_in = 32'sh80000000; sat_in = 1'b1;
            end else begin
               res_in = 32'(sum);      sat_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff   <= op_in;
      cnt_ff  <= cnt_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      neg_ff  <= neg_in;
      a_ff    <= a_in;
      prod_ff <= prod_in;
      res_ff  <= res_in;
      sat_ff  <= sat_in;
   end

   assign res      = res_ff;
   assign sts.done = done_ff;
   assign sts.sat  = sat_ff;

endmodule

>>> sv/nldm_table_bilinear_lookup_core.sv
// Writes and binds: accept, S_MAP, then the result beat in S_OUT; back to S_IDLE when taken.
// Queries: scan and divide per axis, fetch four entries, three lerps, then the result beat.
// Each axis divide is skipped on a zero gap; each axis point scanned takes an
// S_*SCAN_REQ and an S_*SCAN state (up to 6 points per axis). One item at a time.
// Synchronous active-high reset clears control state; memories are undefined
// until written.
module nldm_table_bilinear_lookup_core
   import nldm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_action,
   input  logic [5:0]         req_table_index,
   input  logic [3:0]         req_template_index,
   input  logic [2:0]         req_row,
   input  logic [2:0]         req_col,
   input  logic               req_axis_select,
   input  logic [2:0]         req_axis_position,
   input  logic signed [31:0] req_entry_value,
   input  logic signed [31:0] req_query_slew,
   input  logic signed [31:0] req_query_load,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_result_value,
   output logic [1:0]         rsp_status
);

   localparam int unsigned CELLS  = GRID_POINTS * GRID_POINTS;
   localparam int unsigned TAB_W  = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
   localparam int unsigned TPL_W  = (NUM_TEMPLATES > 1) ? $clog2(NUM_TEMPLATES) : 1;
   localparam int unsigned PT_W   = $clog2(GRID_POINTS);
   localparam int unsigned TD     = NUM_TABLES * CELLS;
   localparam int unsigned AD     = NUM_TEMPLATES * 2 * GRID_POINTS;
   localparam int unsigned TA_W   = $clog2(TD);
   localparam int unsigned AA_W   = $clog2(AD);

   // memories
   logic signed [31:0] tmem [TD];
   logic signed [31:0] amem [AD];
   logic [TPL_W-1:0]   mmem [NUM_TABLES];

   state_type st_ff, st_in;

   // latched request
   action_type         act_ff;
   logic [TAB_W-1:0]   tab_ff;
   logic [TPL_W-1:0]   tpl_ff;
   logic [2:0]         row_ff, col_ff, pos_ff;
   logic               sel_ff;
   logic signed [31:0] val_ff, qs_ff, ql_ff;

   logic [TPL_W-1:0]   t_ff, t_in;
   logic [PT_W-1:0]    k_ff, k_in, y1_ff, y1_in, x1_ff, x1_in;
   logic signed [31:0] alo_ff, alo_in;
   logic signed [31:0] fy_ff, fy_in, fx_ff, fx_in;
   logic signed [31:0] lu_ff, lu_in, ru_ff, ru_in, ld_ff, ld_in, rd_ff, rd_in;
   logic signed [31:0] m1_ff, m1_in, m2_ff, m2_in;
   logic               gap_ff, gap_in, sat_ff, sat_in;
   logic signed [31:0] rv_ff, rv_in;
   logic [1:0]         rs_ff, rs_in;

   logic [AA_W-1:0]    ara;
   logic [TA_W-1:0]    tra;
   logic signed [31:0] ard_ff, trd_ff;
   logic [TPL_W-1:0]   mrd_ff;

   alu_ctl_type        ctl;
   alu_sts_type        asts;
   logic signed [32:0] opa, opb;
   logic signed [31:0] opf, ares;

   logic               accept;
   logic signed [32:0] dq;
   logic signed [31:0] qv;

   nldm_alu u_alu (
      .clock(clock), .reset(reset), .ctl(ctl),
      .opa(opa), .opb(opb), .opf(opf), .res(ares), .sts(asts)
   );

   assign accept    = req_valid && req_ready;
   assign req_ready = (st_ff == S_IDLE);
   assign rsp_valid = (st_ff == S_OUT);
   assign rsp_result_value = rv_ff;
   assign rsp_status       = rs_ff;

   // request latch; writes reach the memories through the write stage below
   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff <= action_type'(req_action);
         tab_ff <= req_table_index;
         tpl_ff <= req_template_index;
         row_ff <= req_row;
         col_ff <= req_col;
         sel_ff <= req_axis_select;
         pos_ff <= req_axis_position;
         val_ff <= req_entry_value;
         qs_ff  <= req_query_slew;
         ql_ff  <= req_query_load;
      end
   end

   // write stage, in the cycle after accept; binding read off the request itself
   logic wr_ff;
   always_ff @(posedge clock) begin
      if (reset) wr_ff <= 1'b0;
      else       wr_ff <= accept;
      if (wr_ff && act_ff == ACT_ENTRY && 32'(row_ff) < GRID_POINTS
          && 32'(col_ff) < GRID_POINTS)
         tmem[TA_W'(32'(tab_ff) * CELLS + 32'(row_ff) * GRID_POINTS + 32'(col_ff))]
            <= val_ff;
      if (wr_ff && act_ff == ACT_AXIS && 32'(pos_ff) < GRID_POINTS)
         amem[AA_W'((32'(tpl_ff) * 2 + 32'(sel_ff)) * GRID_POINTS + 32'(pos_ff))]
            <= val_ff;
      if (wr_ff && act_ff == ACT_BIND)
         mmem[tab_ff] <= tpl_ff;
      ard_ff <= amem[ara];
      trd_ff <= tmem[tra];
      mrd_ff <= mmem[req_table_index];
   end

   // memory read addresses
   always_comb begin
      ara = '0;
      tra = '0;
      case (st_ff)
         S_TSCAN_REQ, S_TSCAN:
            ara = AA_W'((32'(t_ff) * 2) * GRID_POINTS + 32'(k_ff));
         S_THI:
            ara = AA_W'((32'(t_ff) * 2) * GRID_POINTS + 32'(k_ff) + 1);
         S_LSCAN_REQ, S_LSCAN:
            ara = AA_W'((32'(t_ff) * 2 + 1) * GRID_POINTS + 32'(k_ff));
         S_LHI:
            ara = AA_W'((32'(t_ff) * 2 + 1) * GRID_POINTS + 32'(k_ff) + 1);
         S_E0:
            tra = TA_W'(32'(tab_ff) * CELLS + 32'(y1_ff) * GRID_POINTS + 32'(x1_ff));
         S_E1:
            tra = TA_W'(32'(tab_ff) * CELLS + 32'(y1_ff) * GRID_POINTS
                        + 32'(x1_ff) + 1);
         S_E2:
            tra = TA_W'(32'(tab_ff) * CELLS + (32'(y1_ff) + 1) * GRID_POINTS
                        + 32'(x1_ff));
         S_E3:
            tra = TA_W'(32'(tab_ff) * CELLS + (32'(y1_ff) + 1) * GRID_POINTS
                        + 32'(x1_ff) + 1);
         default: ;
      endcase
   end

   // scan: ard_ff in S_TSCAN/S_LSCAN holds axis[k]; S_*DIV holds axis[k+1]
   assign qv = (st_ff == S_TSCAN || st_ff == S_TDIV) ? qs_ff : ql_ff;
   assign dq = 33'(ard_ff) - 33'(alo_ff);

   // next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         S_IDLE:      if (accept) st_in = S_MAP;
         S_MAP:       st_in = (act_ff == ACT_QUERY) ? S_TSCAN_REQ : S_OUT;
         S_TSCAN_REQ: st_in = S_TSCAN;
         S_TSCAN:     if (k_ff == '0 || !(ard_ff > qs_ff)) st_in = S_THI;
                      else st_in = S_TSCAN_REQ;
         S_THI:       st_in = S_TDIV;
         S_TDIV:      st_in = (dq == '0) ? S_LSCAN_REQ : S_TWAIT;
         S_TWAIT:     if (asts.done) st_in = S_LSCAN_REQ;
         S_LSCAN_REQ: st_in = S_LSCAN;
         S_LSCAN:     if (k_ff == '0 || !(ard_ff > ql_ff)) st_in = S_LHI;
                      else st_in = S_LSCAN_REQ;
         S_LHI:       st_in = S_LDIV;
         S_LDIV:      st_in = (dq == '0) ? S_E0 : S_LWAIT;
         S_LWAIT:     if (asts.done) st_in = S_E0;
         S_E0:        st_in = S_E1;
         S_E1:        st_in = S_E2;
         S_E2:        st_in = S_E3;
         S_E3:        st_in = S_E4;
         S_E4:        st_in = S_M1;
         S_M1:        st_in = S_M1W;
         S_M1W:       if (asts.done) st_in = S_M2;
         S_M2:        st_in = S_M2W;
         S_M2W:       if (asts.done) st_in = S_R;
         S_R:         st_in = S_RW;
         S_RW:        if (asts.done) st_in = S_OUT;
         S_OUT:       if (rsp_ready) st_in = S_IDLE;
         default:     st_in = S_IDLE;
      endcase
   end

   // datapath and unit control
   always_comb begin
      t_in   = t_ff;   k_in  = k_ff;   y1_in = y1_ff; x1_in = x1_ff;
      alo_in = alo_ff; fy_in = fy_ff;  fx_in = fx_ff;
      lu_in  = lu_ff;  ru_in = ru_ff;  ld_in = ld_ff; rd_in = rd_ff;
      m1_in  = m1_ff;  m2_in = m2_ff;
      gap_in = gap_ff; sat_in = sat_ff;
      rv_in  = rv_ff;  rs_in  = rs_ff;
      ctl.start = 1'b0;
      ctl.op    = OP_DIV;
      opa = dq;
      opb = 33'(qv) - 33'(alo_ff);
      opf = fx_ff;
      case (st_ff)
         S_MAP: begin
            t_in   = mrd_ff;
            k_in   = PT_W'(GRID_POINTS - 2);
            gap_in = 1'b0;
            sat_in = 1'b0;
            rv_in  = '0;
            rs_in  = ST_WRITE;
         end
         S_TSCAN, S_LSCAN: begin
            alo_in = ard_ff;
            if (k_ff == '0 || !(ard_ff > qv)) begin
               if (st_ff == S_TSCAN) y1_in = k_ff;
               else                  x1_in = k_ff;
            end else begin
               k_in = k_ff - 1'b1;
            end
         end
         S_TDIV, S_LDIV: begin
            // numerator q - a_lo, denominator a_hi - a_lo, both 33 bits
            opa = 33'(qv) - 33'(alo_ff);
            opb = dq;
            if (dq == '0) begin
               gap_in = 1'b1;
               if (st_ff == S_TDIV) fy_in = '0;
               else                 fx_in = '0;
            end else begin
               ctl.start = 1'b1;
            end
            k_in = PT_W'(GRID_POINTS - 2);
         end
         S_TWAIT: if (asts.done) begin
            fy_in = ares; sat_in = sat_ff | asts.sat;
         end
         S_LWAIT: if (asts.done) begin
            fx_in = ares; sat_in = sat_ff | asts.sat;
         end
         S_E1: lu_in = trd_ff;
         S_E2: ru_in = trd_ff;
         S_E3: ld_in = trd_ff;
         S_E4: rd_in = trd_ff;
         S_M1: begin
            ctl.start = 1'b1; ctl.op = OP_LERP;
            opa = 33'(lu_ff); opb = 33'(ru_ff); opf = fx_ff;
         end
         S_M1W: if (asts.done) begin
            m1_in = ares; sat_in = sat_ff | asts.sat;
         end
         S_M2: begin
            ctl.start = 1'b1; ctl.op = OP_LERP;
            opa = 33'(ld_ff); opb = 33'(rd_ff); opf = fx_ff;
         end
         S_M2W: if (asts.done) begin
            m2_in = ares; sat_in = sat_ff | asts.sat;
         end
         S_R: begin
            ctl.start = 1'b1; ctl.op = OP_LERP;
            opa = 33'(m1_ff); opb = 33'(m2_ff); opf = fy_ff;
         end
         S_RW: if (asts.done) begin
            rv_in = ares;
            if (sat_ff | asts.sat) rs_in = ST_SAT;
            else if (gap_ff)       rs_in = ST_GAP;
            else                   rs_in = ST_OK;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) st_ff <= S_IDLE;
      else       st_ff <= st_in;
      t_ff <= t_in;   k_ff <= k_in;   y1_ff <= y1_in; x1_ff <= x1_in;
      alo_ff <= alo_in; fy_ff <= fy_in; fx_ff <= fx_in;
      lu_ff <= lu_in; ru_ff <= ru_in; ld_ff <= ld_in; rd_ff <= rd_in;
      m1_ff <= m1_in; m2_ff <= m2_in;
      gap_ff <= gap_in; sat_ff <= sat_in;
      rv_ff <= rv_in; rs_ff <= rs_in;
   end

endmodule
